>>> sv/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types, opcode constants and helpers for the stack bytecode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

    // Result kinds
    localparam logic [2:0] KIND_STACK   = 3'd0;
    localparam logic [2:0] KIND_SPECIAL = 3'd1;
    localparam logic [2:0] KIND_SEND    = 3'd2;
    localparam logic [2:0] KIND_RETURN  = 3'd3;
    localparam logic [2:0] KIND_JUMP    = 3'd4;
    localparam logic [2:0] KIND_PRIM    = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;
    localparam logic [2:0] KIND_TRUNC   = 3'd7;

    // Opcode range bounds
    localparam logic [7:0] OP_STACK_LAST      = 8'h5F;
    localparam logic [7:0] OP_EXT_STACK_FIRST = 8'h60;
    localparam logic [7:0] OP_EXT_STACK_LAST  = 8'h65;
    localparam logic [7:0] OP_SPECIAL_FIRST   = 8'h67;
    localparam logic [7:0] OP_SPECIAL_LAST    = 8'h6D;
    localparam logic [7:0] OP_SEND_FIRST      = 8'h70;
    localparam logic [7:0] OP_SEND_LAST       = 8'h71;
    localparam logic [7:0] OP_EXT_SEND_FIRST  = 8'h72;
    localparam logic [7:0] OP_EXT_SEND_LAST   = 8'h73;
    localparam logic [7:0] OP_RETURN_FIRST    = 8'h78;
    localparam logic [7:0] OP_RETURN_LAST     = 8'h7D;
    localparam logic [7:0] OP_JUMP_FIRST      = 8'h80;
    localparam logic [7:0] OP_JUMP_LAST       = 8'h8F;
    localparam logic [7:0] OP_PRIM_FIRST      = 8'hF0;
    localparam logic [7:0] SEL_MASK           = 8'h1F;

    // Pending operand byte counts
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // Instruction lengths
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  sub_op;
        logic        extended;
        logic [11:0] operand_index;
        logic [7:0]  arg_count;
        logic [1:0]  length;
    } sbd_result_t;

    // Operand bytes that follow a given opcode
    function automatic logic [1:0] operand_need(input logic [7:0] c);
        logic [1:0] need;
        need = PEND_NONE;
        if (c >= OP_EXT_STACK_FIRST && c <= OP_EXT_STACK_LAST) need = PEND_ONE;
        else if (c >= OP_SEND_FIRST && c <= OP_SEND_LAST)      need = PEND_ONE;
        else if (c >= OP_EXT_SEND_FIRST && c <= OP_EXT_SEND_LAST) need = PEND_TWO;
        else if (c >= OP_PRIM_FIRST)                           need = PEND_ONE;
        return need;
    endfunction

endpackage

`default_nettype wire

>>> sv/stack_bytecode_decoder.sv
// ----------------------------------------------------------------------------
// stack_bytecode_decoder
// Decodes a stack-machine bytecode stream, one byte per item, into one
// instruction result per completed (or cut-off) instruction.
// ----------------------------------------------------------------------------
// Timing: a completing byte waits in the input register, is decoded into the result
//   register once that has room, and leaves when out_ready takes it.
// Throughput: one byte per cycle while results drain; decode is a single pass between registers.
// Reset: rst_n clears valid flags, pending count and held bytes; the decoder
//   then awaits an opcode with in_ready high.
`default_nettype none

module stack_bytecode_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  code_byte,
    input  wire logic        end_of_method,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [2:0]       sub_op,
    output logic             extended,
    output logic [11:0]      operand_index,
    output logic [7:0]       arg_count,
    output logic [1:0]       length
);
    import sbd_pkg::*;

    logic        s1_valid;
    logic [7:0]  s1_code;
    logic        s1_eom;
    logic        consume;
    logic        load;
    logic        out_free;
    sbd_result_t dec_res;
    sbd_result_t out_res;

    sbd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_byte     (code_byte),
        .end_of_method (end_of_method),
        .consume       (consume),
        .s1_valid      (s1_valid),
        .s1_code       (s1_code),
        .s1_eom        (s1_eom)
    );

    sbd_decode u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_code  (s1_code),
        .s1_eom   (s1_eom),
        .out_free (out_free),
        .consume  (consume),
        .load     (load),
        .res      (dec_res)
    );

    sbd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (dec_res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign sub_op        = out_res.sub_op;
    assign extended      = out_res.extended;
    assign operand_index = out_res.operand_index;
    assign arg_count     = out_res.arg_count;
    assign length        = out_res.length;

`ifndef SYNTHESIS
    // Every delivered instruction spans one to three bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length != 2'd0)
        else $error("stack_bytecode_decoder: zero length result");

    // Extended form only on stack and send results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && extended |-> (kind == KIND_STACK || kind == KIND_SEND))
        else $error("stack_bytecode_decoder: extended flag on wrong kind");

    // Argument counts appear on sends only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_SEND |-> arg_count == 8'd0)
        else $error("stack_bytecode_decoder: arg count on non-send");

    // Sends always carry at least one operand byte beyond the opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SEND |-> length != LEN_ONE)
        else $error("stack_bytecode_decoder: one-byte send");
`endif

endmodule

`default_nettype wire

>>> sv/sbd_in_stage.sv
// ----------------------------------------------------------------------------
// sbd_in_stage
// Input register: captures one bytecode item per cycle ahead of decode, while decode consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] code_byte,
    input  wire logic       end_of_method,
    input  wire logic       consume,
    output logic            s1_valid,
    output logic [7:0]      s1_code,
    output logic            s1_eom
);
    import sbd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] code_reg;
    logic       eom_reg;

    // Free when empty or when the held item leaves this cycle
    assign in_ready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= code_byte;
            eom_reg  <= end_of_method;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_code  = code_reg;
    assign s1_eom   = eom_reg;

endmodule

`default_nettype wire

>>> sv/sbd_decode.sv
// ----------------------------------------------------------------------------
// sbd_decode
// Instruction state (pending count, held opcode and operand) and decode.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_decode (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s1_valid,
    input  wire logic [7:0]           s1_code,
    input  wire logic                 s1_eom,
    input  wire logic                 out_free,
    output logic                      consume,
    output logic                      load,
    output sbd_pkg::sbd_result_t      res
);
    import sbd_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic [7:0] held_opcode_reg, held_opcode_next;
    logic [7:0] held_operand_reg, held_operand_next;
    logic       has_result;
    logic [1:0] need;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] special_off;

    assign b           = s1_code;
    assign c           = held_opcode_reg;
    assign need        = operand_need(b);
    assign special_off = b - OP_SPECIAL_FIRST;

    // Decode and next state
    always_comb
    begin
        pending_next      = pending_reg;
        held_opcode_next  = held_opcode_reg;
        held_operand_next = held_operand_reg;
        has_result        = 1'b0;
        res               = '0;
        unique case (pending_reg)
            PEND_TWO:
            begin
                held_operand_next = b;
                if (s1_eom)
                begin
                    pending_next      = PEND_NONE;
                    has_result        = 1'b1;
                    res.kind          = KIND_TRUNC;
                    res.operand_index = {4'd0, c};
                    res.length        = LEN_TWO;
                end
                else
                begin
                    pending_next = PEND_ONE;
                end
            end
            PEND_ONE:
            begin
                pending_next = PEND_NONE;
                has_result   = 1'b1;
                res.length   = LEN_TWO;
                if (c >= OP_EXT_STACK_FIRST && c <= OP_EXT_STACK_LAST)
                begin
                    res.kind          = KIND_STACK;
                    res.sub_op        = c[2:0];
                    res.extended      = 1'b1;
                    res.operand_index = {4'd0, b};
                end
                else if (c >= OP_SEND_FIRST && c <= OP_SEND_LAST)
                begin
                    res.kind          = KIND_SEND;
                    res.sub_op        = {2'd0, c[0]};
                    res.operand_index = {4'd0, b & SEL_MASK};
                    res.arg_count     = {5'd0, b[7:5]};
                end
                else if (c >= OP_EXT_SEND_FIRST && c <= OP_EXT_SEND_LAST)
                begin
                    // 0x72 is self, 0x73 is super
                    res.kind          = KIND_SEND;
                    res.sub_op        = {2'd0, c[0]};
                    res.extended      = 1'b1;
                    res.operand_index = {4'd0, b};
                    res.arg_count     = held_operand_reg;
                    res.length        = LEN_THREE;
                end
                else
                begin
                    res.kind          = KIND_PRIM;
                    res.operand_index = {c[3:0], b};
                end
            end
            PEND_NONE:
            begin
                has_result = 1'b1;
                res.length = LEN_ONE;
                if (need != PEND_NONE)
                begin
                    held_opcode_next = b;
                    if (s1_eom)
                    begin
                        res.kind          = KIND_TRUNC;
                        res.operand_index = {4'd0, b};
                    end
                    else
                    begin
                        has_result   = 1'b0;
                        pending_next = need;
                    end
                end
                else if (b <= OP_STACK_LAST)
                begin
                    res.kind          = KIND_STACK;
                    res.sub_op        = b[6:4];
                    res.operand_index = {8'd0, b[3:0]};
                end
                else if (b >= OP_SPECIAL_FIRST && b <= OP_SPECIAL_LAST)
                begin
                    res.kind   = KIND_SPECIAL;
                    res.sub_op = special_off[2:0];
                end
                else if (b >= OP_RETURN_FIRST && b <= OP_RETURN_LAST)
                begin
                    res.kind   = KIND_RETURN;
                    res.sub_op = b[2:0];
                end
                else if (b >= OP_JUMP_FIRST && b <= OP_JUMP_LAST)
                begin
                    res.kind          = KIND_JUMP;
                    res.operand_index = {8'd0, b[3:0]};
                end
                else
                begin
                    res.kind          = KIND_UNKNOWN;
                    res.operand_index = {4'd0, b};
                end
            end
            default:
            begin
                pending_next = PEND_NONE;
            end
        endcase
    end

    // Item leaves the input register when it yields no result or its result has a place to go
    assign consume = s1_valid && (!has_result || out_free);
    assign load    = s1_valid && has_result && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= PEND_NONE;
            held_opcode_reg  <= '0;
            held_operand_reg <= '0;
        end
        else if (consume)
        begin
            pending_reg      <= pending_next;
            held_opcode_reg  <= held_opcode_next;
            held_operand_reg <= held_operand_next;
        end
    end

`ifndef SYNTHESIS
    // Pending count never reaches three
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("sbd_decode: illegal pending count");

    // Two bytes pending only after an extended send opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == PEND_TWO |->
            (held_opcode_reg == OP_EXT_SEND_FIRST || held_opcode_reg == OP_EXT_SEND_LAST))
        else $error("sbd_decode: two pending without extended send");

    // One byte pending only after an opcode that takes operands
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == PEND_ONE |-> operand_need(held_opcode_reg) != PEND_NONE)
        else $error("sbd_decode: pending operand after plain opcode");

    // A result is never loaded without consuming its item
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> consume)
        else $error("sbd_decode: load without consume");
`endif

endmodule

`default_nettype wire

>>> sv/sbd_out_stage.sv
// ----------------------------------------------------------------------------
// sbd_out_stage
// Result register: holds one decoded item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire sbd_pkg::sbd_result_t res,
    output logic                      out_free,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sbd_pkg::sbd_result_t      out_res
);
    import sbd_pkg::*;

    logic        valid_reg, valid_next;
    sbd_result_t res_reg;

    // Register can take a new item when empty or being drained
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

>>> tb/sbd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_result_checker
// Watches both channels of the bytecode decoder, decodes every accepted code
// byte on its own and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------

module sbd_result_checker
    import sbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        end_of_method,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  logic [2:0]  sub_op,
    input  logic        extended,
    input  logic [11:0] operand_index,
    input  logic [7:0]  arg_count,
    input  logic [1:0]  length,
    output int          fail_count,
    output int          pending_results,
    output int          compared,
    output int          truncated_seen
);

    // Results still owed by the block, oldest first
    sbd_result_t decoded_q[$];

    // Decoder state as the stream has left it
    logic [1:0] opnd_left;
    logic [7:0] held_op;
    logic [7:0] held_arg;

    int errors;
    int checked;
    int truncs;

    // Decode one code byte; returns 1 when it completes (or cuts off) an item
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output sbd_result_t r);
        logic [1:0] need;
        r = '0;
        // first operand of an extended send: held, or cut off on an end mark
        if (opnd_left == PEND_TWO) begin
            held_arg = b;
            if (last) begin
                opnd_left       = PEND_NONE;
                r.kind          = KIND_TRUNC;
                r.operand_index = {4'h0, held_op};
                r.length        = LEN_TWO;
                return 1'b1;
            end
            opnd_left = PEND_ONE;
            return 1'b0;
        end
        // final operand byte: always completes, end mark has no effect
        if (opnd_left == PEND_ONE) begin
            opnd_left = PEND_NONE;
            r.length  = LEN_TWO;
            if (held_op >= OP_EXT_STACK_FIRST && held_op <= OP_EXT_STACK_LAST) begin
                r.kind          = KIND_STACK;
                r.sub_op        = held_op[2:0];
                r.extended      = 1'b1;
                r.operand_index = {4'h0, b};
            end
            else if (held_op >= OP_SEND_FIRST && held_op <= OP_SEND_LAST) begin
                r.kind          = KIND_SEND;
                r.sub_op        = 3'(held_op - OP_SEND_FIRST);
                r.operand_index = {4'h0, b & SEL_MASK};
                r.arg_count     = {5'h0, b[7:5]};
            end
            else if (held_op >= OP_EXT_SEND_FIRST && held_op <= OP_EXT_SEND_LAST) begin
                r.kind          = KIND_SEND;
                r.sub_op        = 3'(held_op - OP_EXT_SEND_FIRST);
                r.extended      = 1'b1;
                r.operand_index = {4'h0, b};
                r.arg_count     = held_arg;
                r.length        = LEN_THREE;
            end
            else begin
                r.kind          = KIND_PRIM;
                r.operand_index = {held_op[3:0], b};
            end
            return 1'b1;
        end
        // opcode byte: see how many operand bytes follow
        need = PEND_NONE;
        if (b >= OP_EXT_STACK_FIRST && b <= OP_EXT_STACK_LAST)
            need = PEND_ONE;
        else if (b >= OP_SEND_FIRST && b <= OP_SEND_LAST)
            need = PEND_ONE;
        else if (b >= OP_EXT_SEND_FIRST && b <= OP_EXT_SEND_LAST)
            need = PEND_TWO;
        else if (b >= OP_PRIM_FIRST)
            need = PEND_ONE;
        if (need != PEND_NONE) begin
            held_op = b;
            if (last) begin
                r.kind          = KIND_TRUNC;
                r.operand_index = {4'h0, b};
                r.length        = LEN_ONE;
                return 1'b1;
            end
            opnd_left = need;
            return 1'b0;
        end
        // single-byte instructions
        r.length = LEN_ONE;
        if (b <= OP_STACK_LAST) begin
            r.kind          = KIND_STACK;
            r.sub_op        = b[6:4];
            r.operand_index = {8'h0, b[3:0]};
        end
        else if (b >= OP_SPECIAL_FIRST && b <= OP_SPECIAL_LAST) begin
            r.kind   = KIND_SPECIAL;
            r.sub_op = 3'(b - OP_SPECIAL_FIRST);
        end
        else if (b >= OP_RETURN_FIRST && b <= OP_RETURN_LAST) begin
            r.kind   = KIND_RETURN;
            r.sub_op = 3'(b - OP_RETURN_FIRST);
        end
        else if (b >= OP_JUMP_FIRST && b <= OP_JUMP_LAST) begin
            r.kind          = KIND_JUMP;
            r.operand_index = {8'h0, b[3:0]};
        end
        else begin
            r.kind          = KIND_UNKNOWN;
            r.operand_index = {4'h0, b};
        end
        return 1'b1;
    endfunction

    // Compare results leaving, then decode bytes entering
    always @(posedge clk or negedge rst_n)
    begin : watch
        sbd_result_t got;
        sbd_result_t want;
        sbd_result_t nxt;
        if (!rst_n)
        begin
            opnd_left = PEND_NONE;
            held_op   = '0;
            held_arg  = '0;
            errors    = 0;
            checked   = 0;
            truncs    = 0;
            decoded_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {kind, sub_op, extended, operand_index, arg_count, length};
                checked++;
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none due: kind=%0d sub=%0d ext=%0d idx=%0h args=%0d len=%0d",
                                 $realtime, got.kind, got.sub_op, got.extended,
                                 got.operand_index, got.arg_count, got.length);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch kind %0d/%0d sub %0d/%0d ext %0d/%0d idx %0h/%0h args %0d/%0d len %0d/%0d (exp/got)",
                                     $realtime, want.kind, got.kind, want.sub_op, got.sub_op,
                                     want.extended, got.extended, want.operand_index,
                                     got.operand_index, want.arg_count, got.arg_count,
                                     want.length, got.length);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (decode_byte(code_byte, end_of_method, nxt))
                begin
                    decoded_q.push_back(nxt);
                    if (nxt.kind == KIND_TRUNC)
                        truncs++;
                end
            end
        end
        fail_count      <= errors;
        pending_results <= decoded_q.size();
        compared        <= checked;
        truncated_seen  <= truncs;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bytecode streams into the stack bytecode decoder: a directed pass
// over every opcode family and cut-off case, then random instruction streams
// with random gaps, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------

module testbench;
    import sbd_pkg::*;

    localparam logic [7:0] OP_STACK_FIRST = 8'h00;
    localparam int         RAND_ITEMS     = 1350;
    localparam int         NUM_PHASES     = 5;
    localparam int         HOLD_CYCLES    = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  code_byte;
    logic        end_of_method;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [2:0]  sub_op;
    logic        extended;
    logic [11:0] operand_index;
    logic [7:0]  arg_count;
    logic [1:0]  length;

    int fail_count;
    int pending_results;
    int compared;
    int truncated_seen;

    // Idling controls for sender and receiver, and the sent byte count
    bit tx_idle;
    bit rx_idle;
    int rx_hold_len;
    int bytes_sent;

    stack_bytecode_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_byte     (code_byte),
        .end_of_method (end_of_method),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .sub_op        (sub_op),
        .extended      (extended),
        .operand_index (operand_index),
        .arg_count     (arg_count),
        .length        (length)
    );

    sbd_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .code_byte       (code_byte),
        .end_of_method   (end_of_method),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .sub_op          (sub_op),
        .extended        (extended),
        .operand_index   (operand_index),
        .arg_count       (arg_count),
        .length          (length),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .compared        (compared),
        .truncated_seen  (truncated_seen)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("stack_bytecode_decoder verification failed");
        $finish;
    end

    // Offer one code byte and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        code_byte     <= b;
        end_of_method <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // One random instruction, well formed in most cases, with random end marks
    task automatic send_instr();
        logic [7:0] opc;
        int         n_opnd;
        n_opnd = 0;
        case ($urandom_range(0, 9))
            0: opc = 8'($urandom_range(OP_STACK_FIRST, OP_STACK_LAST));
            1:
            begin
                opc    = 8'($urandom_range(OP_EXT_STACK_FIRST, OP_EXT_STACK_LAST));
                n_opnd = 1;
            end
            2: opc = 8'($urandom_range(OP_SPECIAL_FIRST, OP_SPECIAL_LAST));
            3:
            begin
                opc    = 8'($urandom_range(OP_SEND_FIRST, OP_SEND_LAST));
                n_opnd = 1;
            end
            4:
            begin
                opc    = 8'($urandom_range(OP_EXT_SEND_FIRST, OP_EXT_SEND_LAST));
                n_opnd = 2;
            end
            5: opc = 8'($urandom_range(OP_RETURN_FIRST, OP_RETURN_LAST));
            6: opc = 8'($urandom_range(OP_JUMP_FIRST, OP_JUMP_LAST));
            7:
            begin
                opc    = 8'($urandom_range(OP_PRIM_FIRST, 8'hFF));
                n_opnd = 1;
            end
            default: opc = 8'($urandom_range(0, 255));   // noise, unknown codes too
        endcase
        send_byte(opc, $urandom_range(0, 11) == 0);
        repeat (n_opnd) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
    endtask

    // Stop offering and wait until every due result has left the block
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    // Receiver: random stalls per item, plus an on-demand long hold
    initial
    begin : receiver
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (rx_hold_len > 0)
            begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int directed_n;
        int phase_end;
        int drain_wait;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        code_byte     = '0;
        end_of_method = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold_len   = 0;
        bytes_sent    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, each family, unknown gaps, cut-offs
        send_byte(OP_STACK_FIRST, 1'b0);
        send_byte(OP_STACK_LAST, 1'b0);
        send_byte(OP_EXT_STACK_FIRST, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(OP_EXT_STACK_LAST, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OP_EXT_STACK_LAST + 8'd1, 1'b0);
        send_byte(OP_SPECIAL_FIRST, 1'b0);
        send_byte(OP_SPECIAL_LAST, 1'b0);
        send_byte(OP_SEND_FIRST, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OP_SEND_LAST, 1'b0);
        send_byte(8'h00, 1'b1);                      // end mark on final byte
        send_byte(OP_EXT_SEND_FIRST, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(OP_PRIM_FIRST, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OP_RETURN_LAST, 1'b0);
        send_byte(OP_JUMP_LAST, 1'b0);
        send_byte(OP_PRIM_FIRST - 8'd1, 1'b0);
        send_byte(OP_EXT_SEND_FIRST, 1'b1);          // cut off after opcode
        send_byte(OP_EXT_SEND_LAST, 1'b0);
        send_byte(8'h05, 1'b1);                      // cut off after first operand
        send_byte(OP_EXT_STACK_FIRST, 1'b1);
        directed_n = bytes_sent;

        // Random phases with different idling patterns
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
                1:
                begin
                    // receiver holds off while the sender keeps pushing
                    tx_idle     = 1'b0;
                    rx_idle     = 1'b1;
                    rx_hold_len = HOLD_CYCLES;
                end
                2:
                begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                3:
                begin
                    drain();
                    tx_idle = 1'b1;
                    rx_idle = 1'b0;
                end
                default:
                begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b1;
                end
            endcase
            phase_end = directed_n + (phase + 1) * RAND_ITEMS / NUM_PHASES;
            while (bytes_sent < phase_end)
                send_instr();
        end

        // Wait out the remaining results, bounded
        in_valid <= 1'b0;
        @(posedge clk);
        drain_wait = 0;
        while (pending_results != 0 && drain_wait < 2000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (12) @(posedge clk);

        $display("Covered %0d code bytes (%0d directed), %0d results compared, %0d cut off",
                 bytes_sent, directed_n, compared, truncated_seen);
        $display("Idling patterns included a %0d-cycle output hold and a full drain pause",
                 HOLD_CYCLES);
        if (pending_results != 0)
            $display("%0d expected results never arrived", pending_results);
        if (fail_count == 0 && pending_results == 0)
            $display("stack_bytecode_decoder verification clean");
        else
            $display("stack_bytecode_decoder verification failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/sbd_pkg.sv
sv/sbd_in_stage.sv
sv/sbd_decode.sv
sv/sbd_out_stage.sv
sv/stack_bytecode_decoder.sv
tb/sbd_result_checker.sv
tb/testbench.sv
